FILE: sv/mbox_stream_splitter_unit_macros.svh
// ----------------------------------------------------------------------------
// mbox stream splitter assertion macros
// Concurrent check helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef MBOX_STREAM_SPLITTER_UNIT_MACROS_SVH
`define MBOX_STREAM_SPLITTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mss assertion failed");
// next-cycle implication
`define MSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mss assertion failed");
`else
`define MSS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MSS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg
// Types, codes and constants shared by the mbox stream splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mss_pkg;

    localparam int MSS_CMD_DEPTH = 4;
    localparam int MSS_PTR_W     = $clog2(MSS_CMD_DEPTH);
    localparam int MSS_CNT_W     = $clog2(MSS_CMD_DEPTH + 1);

    localparam logic [7:0] CH_F  = 8'h46;  // 'F'
    localparam logic [7:0] CH_GT = 8'h3E;  // '>'
    localparam logic [7:0] CH_AT = 8'h40;  // '@'
    localparam logic [7:0] CH_NL = 8'h0A;  // newline

    typedef enum logic {
        OP_DATA = 1'b0,
        OP_EOI  = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        K_MSG   = 3'd0,
        K_SEPB  = 3'd1,
        K_START = 3'd2,
        K_WARN  = 3'd3,
        K_END   = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        ST_MID    = 4'd0,
        ST_LSTART = 4'd1,
        ST_SEP    = 4'd2,
        ST_F1     = 4'd3,
        ST_F2     = 4'd4,
        ST_F3     = 4'd5,
        ST_F4     = 4'd6,
        ST_Q1     = 4'd7,
        ST_Q2     = 4'd8,
        ST_Q3     = 4'd9,
        ST_Q4     = 4'd10,
        ST_Q5     = 4'd11
    } t_parse_state;

    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    // One classified input byte: a run of held tag bytes, then up to two items.
    typedef struct packed {
        logic       tag_start;  // 0: run starts at '>', 1: at 'F'
        logic [2:0] tag_cnt;
        logic       a_vld;
        t_kind      a_kind;
        logic [7:0] a_byte;
        logic       b_vld;
        t_kind      b_kind;
    } t_cmd;

    // ">From "
    function automatic logic [7:0] mss_tag_byte(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0:    r = 8'h3E;
            3'd1:    r = 8'h46;
            3'd2:    r = 8'h72;
            3'd3:    r = 8'h6F;
            3'd4:    r = 8'h6D;
            3'd5:    r = 8'h20;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] mss_cmd_total(input t_cmd c);
        return c.tag_cnt + {2'b00, c.a_vld} + {2'b00, c.b_vld};
    endfunction

endpackage

FILE: sv/mss_front.sv
// ----------------------------------------------------------------------------
// mss_front
// Line parser: accepts bytes, tracks separator and quote matching, and
// queues at most one result command per byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mss_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mss_pkg::t_in_item i_item,
    input  logic              i_full,
    output logic              o_push,
    output mss_pkg::t_cmd     o_cmd
);
    import mss_pkg::*;

    t_parse_state r_state, n_state;
    logic         r_seen, n_seen;
    logic         r_open, n_open;
    t_cmd         w_cmd;
    logic         w_accept;
    logic [7:0]   w_c;
    logic [3:0]   w_st;
    logic [2:0]   w_f_got;
    logic [2:0]   w_q_got;
    logic         w_nl;

    assign w_accept = i_push && !i_full;
    assign w_c      = i_item.data_byte;
    assign w_st     = r_state;
    assign w_f_got  = 3'(w_st - 4'(ST_F1) + 4'd1);
    assign w_q_got  = 3'(w_st - 4'(ST_Q1) + 4'd1);
    assign w_nl     = (w_c == CH_NL);

    always_comb begin
        n_state = r_state;
        n_seen  = r_seen;
        n_open  = r_open;
        w_cmd   = '0;
        if (i_item.op == OP_EOI) begin
            // held prefix bytes are dropped here
            w_cmd.a_vld  = r_open;
            w_cmd.a_kind = K_END;
            n_open       = 1'b0;
            n_state      = ST_LSTART;
            n_seen       = 1'b0;
        end else begin
            case (r_state)
                ST_LSTART: begin
                    if (w_c == CH_F) begin
                        n_state = ST_F1;
                    end else if (w_c == CH_GT) begin
                        n_state = ST_Q1;
                    end else begin
                        n_state      = w_nl ? ST_LSTART : ST_MID;
                        w_cmd.a_vld  = 1'b1;
                        w_cmd.a_kind = K_MSG;
                        w_cmd.a_byte = w_c;
                    end
                end
                ST_SEP: begin
                    w_cmd.a_vld  = 1'b1;
                    w_cmd.a_kind = K_SEPB;
                    w_cmd.a_byte = w_c;
                    if (w_c == CH_AT) begin
                        n_seen = 1'b1;
                    end
                    if (w_nl) begin
                        w_cmd.b_vld  = !r_seen;
                        w_cmd.b_kind = K_WARN;
                        n_state      = ST_LSTART;
                    end
                end
                ST_F1, ST_F2, ST_F3, ST_F4: begin
                    if (w_c == mss_tag_byte(w_f_got + 3'd1)) begin
                        if (r_state == ST_F4) begin
                            n_state = ST_SEP;
                            n_seen  = 1'b0;
                            n_open  = 1'b1;
                            if (r_open) begin
                                w_cmd.a_vld  = 1'b1;
                                w_cmd.a_kind = K_END;
                                w_cmd.b_vld  = 1'b1;
                                w_cmd.b_kind = K_START;
                            end else begin
                                w_cmd.a_vld  = 1'b1;
                                w_cmd.a_kind = K_START;
                            end
                        end else begin
                            n_state = t_parse_state'(w_st + 4'd1);
                        end
                    end else begin
                        // match failed: flush held bytes, stay mid-line even on newline
                        w_cmd.tag_start = 1'b1;
                        w_cmd.tag_cnt   = w_f_got;
                        w_cmd.a_vld     = 1'b1;
                        w_cmd.a_kind    = K_MSG;
                        w_cmd.a_byte    = w_c;
                        n_state         = ST_MID;
                    end
                end
                ST_Q1, ST_Q2, ST_Q3, ST_Q4, ST_Q5: begin
                    if (w_c == mss_tag_byte(w_q_got)) begin
                        if (r_state == ST_Q5) begin
                            // unquote: emit "From " without the '>'
                            w_cmd.tag_start = 1'b1;
                            w_cmd.tag_cnt   = 3'd5;
                            n_state         = ST_MID;
                        end else begin
                            n_state = t_parse_state'(w_st + 4'd1);
                        end
                    end else begin
                        w_cmd.tag_start = 1'b0;
                        w_cmd.tag_cnt   = w_q_got;
                        w_cmd.a_vld     = 1'b1;
                        w_cmd.a_kind    = K_MSG;
                        w_cmd.a_byte    = w_c;
                        n_state         = ST_MID;
                    end
                end
                default: begin
                    n_state      = w_nl ? ST_LSTART : ST_MID;
                    w_cmd.a_vld  = 1'b1;
                    w_cmd.a_kind = K_MSG;
                    w_cmd.a_byte = w_c;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LSTART;
            r_seen  <= 1'b0;
            r_open  <= 1'b0;
        end else if (w_accept) begin
            r_state <= n_state;
            r_seen  <= n_seen;
            r_open  <= n_open;
        end
    end

    assign o_push = w_accept && (w_cmd.a_vld || (w_cmd.tag_cnt != 3'd0));
    assign o_cmd  = w_cmd;

endmodule

FILE: sv/mss_cmd_fifo.sv
// ----------------------------------------------------------------------------
// mss_cmd_fifo
// Short command queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mss_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mss_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output mss_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import mss_pkg::*;

    t_cmd                 r_mem [MSS_CMD_DEPTH];
    logic [MSS_PTR_W-1:0] r_wptr, n_wptr;
    logic [MSS_PTR_W-1:0] r_rptr, n_rptr;
    logic [MSS_CNT_W-1:0] r_count, n_count;
    logic                 w_wr;
    logic                 w_rd;

    assign o_full  = (r_count == MSS_CNT_W'(MSS_CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_wr) begin
            n_wptr = (r_wptr == MSS_PTR_W'(MSS_CMD_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_rd) begin
            n_rptr = (r_rptr == MSS_PTR_W'(MSS_CMD_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

FILE: sv/mss_back.sv
// ----------------------------------------------------------------------------
// mss_back
// Result sequencer: walks each queued command into the output register, one
// result per cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mss_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mss_pkg::t_cmd      i_cmd,
    input  logic               i_cmd_vld,
    output logic               o_cmd_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output mss_pkg::t_out_item o_result,
    output logic [2:0]         o_idx
);
    import mss_pkg::*;

    logic       r_vld;
    t_out_item  r_out, n_out;
    logic [2:0] r_idx, n_idx;
    logic       w_ld;
    logic       w_last;
    logic [2:0] w_total;

    assign w_ld    = !r_vld || i_pop;
    assign w_total = mss_cmd_total(i_cmd);
    assign w_last  = (r_idx == w_total - 3'd1);

    always_comb begin
        n_out.last = w_last;
        if (r_idx < i_cmd.tag_cnt) begin
            n_out.kind     = K_MSG;
            n_out.out_byte = mss_tag_byte({2'b00, i_cmd.tag_start} + r_idx);
        end else if ((r_idx == i_cmd.tag_cnt) && i_cmd.a_vld) begin
            n_out.kind     = i_cmd.a_kind;
            n_out.out_byte = i_cmd.a_byte;
        end else begin
            n_out.kind     = i_cmd.b_kind;
            n_out.out_byte = 8'h00;
        end
        n_idx = w_last ? 3'd0 : r_idx + 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= 3'd0;
        end else if (w_ld) begin
            r_vld <= i_cmd_vld;
            if (i_cmd_vld) begin
                r_idx <= n_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld && i_cmd_vld) begin
            r_out <= n_out;
        end
    end

    assign o_cmd_pop = w_ld && i_cmd_vld && w_last;
    assign o_empty   = !r_vld;
    assign o_result  = r_out;
    assign o_idx     = r_idx;

endmodule

FILE: sv/mbox_stream_splitter_unit.sv
// ----------------------------------------------------------------------------
// mbox_stream_splitter_unit
// Splits an mbox byte stream into message, separator-line and marker results.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle while full is low. A byte causes zero
// to six results, and the result port delivers one per cycle while pop is
// high, so a byte with many results keeps the result sequencer busy; a
// four-entry command queue between the parser and the sequencer absorbs
// that, and full rises only once it fills (for example while a failed
// "From " or ">From " prefix is flushed). A byte's first result passes
// through the queue entry and then the output register; last is set on the
// final result of each byte. End of input closes the open message and discards any held prefix bytes.
`timescale 1ns / 1ps
`include "mbox_stream_splitter_unit_macros.svh"

module mbox_stream_splitter_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  mss_pkg::t_in_item  i_item,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output mss_pkg::t_out_item o_result
);
    import mss_pkg::*;

    logic       w_fe_push;
    t_cmd       w_fe_cmd;
    logic       w_q_full;
    logic       w_q_empty;
    logic       w_q_pop;
    t_cmd       w_q_cmd;
    logic [2:0] w_be_idx;

    mss_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .i_full  (w_q_full),
        .o_push  (w_fe_push),
        .o_cmd   (w_fe_cmd)
    );

    mss_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fe_push),
        .i_cmd   (w_fe_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_cmd   (w_q_cmd),
        .o_empty (w_q_empty)
    );

    mss_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_q_cmd),
        .i_cmd_vld (!w_q_empty),
        .o_cmd_pop (w_q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result),
        .o_idx     (w_be_idx)
    );

    assign full = w_q_full;

    // queued commands always carry at least one result
    `MSS_ASSERT_IMP(a_cmd_nonempty, i_clk, i_rst_n, w_fe_push, mss_cmd_total(w_fe_cmd) != 3'd0)
    // sequencer is never mid-command without a command at the queue head
    `MSS_ASSERT_IMP(a_idx_idle, i_clk, i_rst_n, w_q_empty, w_be_idx == 3'd0)
    // step index stays inside the head command
    `MSS_ASSERT_IMP(a_idx_range, i_clk, i_rst_n, !w_q_empty, w_be_idx < mss_cmd_total(w_q_cmd))
    // a transfer into an empty queue shows up at its head next cycle
    `MSS_ASSERT_NXT(a_queue_fill, i_clk, i_rst_n, w_fe_push && w_q_empty, !w_q_empty)

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mbox stream splitter. Directed lines cover
// separators with and without '@', the ">From " unquote, failed prefix matches
// and end of input. Line-shaped random traffic follows under three idle
// patterns. An in-bench model predicts every result, and each popped result
// is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import mss_pkg::*;

    localparam int          CYCLE_LIMIT = 200000;
    localparam int          DRAIN_LIMIT = 5000;
    localparam int          TAIL_CYCLES = 20;
    localparam int          MAX_PRINTS  = 40;
    localparam logic [47:0] QUOTE_TAG   = ">From ";

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    t_in_item  i_item;
    logic      full;
    logic      pop;
    logic      empty;
    t_out_item o_result;

    // splitter model state
    logic [3:0] pst;
    bit         seen_at;
    bit         msg_open;
    t_out_item  split_results_q[$];

    int send_idle_pct = 36;
    int recv_idle_pct = 45;
    int cycle_cnt     = 0;
    int n_bad         = 0;
    int n_items       = 0;
    int n_results     = 0;
    int n_seps        = 0;
    int n_warns       = 0;
    int n_quotes      = 0;
    int n_eoi         = 0;

    mbox_stream_splitter_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_item   (i_item),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report_bad(input string msg);
        if (n_bad < MAX_PRINTS)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        n_bad++;
    endtask

    function automatic logic [7:0] tag_at(input int idx);
        return QUOTE_TAG[8 * (5 - idx) +: 8];
    endfunction

    function automatic t_out_item mk_result(input t_kind k, input logic [7:0] b);
        t_out_item r;
        r.kind     = k;
        r.out_byte = b;
        r.last     = 1'b0;
        return r;
    endfunction

    // Splits one accepted input item into its results and queues them.
    function automatic void split_item(input t_in_item it);
        t_out_item  outs[$];
        logic [7:0] c;
        int         got;
        c = it.data_byte;
        if (it.op == OP_EOI) begin
            if (msg_open)
                outs.push_back(mk_result(K_END, 8'h00));
            msg_open = 1'b0;
            pst      = ST_LSTART;
            seen_at  = 1'b0;
            n_eoi++;
        end else if (pst == ST_LSTART) begin
            if (c == CH_F) begin
                pst = ST_F1;
            end else if (c == CH_GT) begin
                pst = ST_Q1;
            end else begin
                if (c != CH_NL)
                    pst = ST_MID;
                outs.push_back(mk_result(K_MSG, c));
            end
        end else if (pst == ST_SEP) begin
            outs.push_back(mk_result(K_SEPB, c));
            if (c == CH_AT)
                seen_at = 1'b1;
            if (c == CH_NL) begin
                if (!seen_at) begin
                    outs.push_back(mk_result(K_WARN, 8'h00));
                    n_warns++;
                end
                pst = ST_LSTART;
            end
        end else if (pst >= ST_F1 && pst <= ST_F4) begin
            got = int'(pst) - int'(ST_F1) + 1;
            if (c == tag_at(got + 1)) begin
                if (got == 4) begin
                    pst     = ST_SEP;
                    seen_at = 1'b0;
                    if (msg_open)
                        outs.push_back(mk_result(K_END, 8'h00));
                    outs.push_back(mk_result(K_START, 8'h00));
                    msg_open = 1'b1;
                    n_seps++;
                end else begin
                    pst = pst + 4'd1;
                end
            end else begin
                // held prefix goes out, then the byte; newline does not re-arm
                for (int i = 1; i <= got; i++)
                    outs.push_back(mk_result(K_MSG, tag_at(i)));
                outs.push_back(mk_result(K_MSG, c));
                pst = ST_MID;
            end
        end else if (pst >= ST_Q1 && pst <= ST_Q5) begin
            got = int'(pst) - int'(ST_Q1) + 1;
            if (c == tag_at(got)) begin
                if (got == 5) begin
                    for (int i = 1; i <= 5; i++)
                        outs.push_back(mk_result(K_MSG, tag_at(i)));
                    pst = ST_MID;
                    n_quotes++;
                end else begin
                    pst = pst + 4'd1;
                end
            end else begin
                for (int i = 0; i < got; i++)
                    outs.push_back(mk_result(K_MSG, tag_at(i)));
                outs.push_back(mk_result(K_MSG, c));
                pst = ST_MID;
            end
        end else begin
            pst = (c == CH_NL) ? ST_LSTART : ST_MID;
            outs.push_back(mk_result(K_MSG, c));
        end
        if (outs.size() > 0)
            outs[outs.size() - 1].last = 1'b1;
        foreach (outs[i])
            split_results_q.push_back(outs[i]);
    endfunction

    // Called right after a rising edge; returns right after the transfer edge.
    task automatic send_item(input t_op op, input logic [7:0] b);
        t_in_item it;
        it.op        = op;
        it.data_byte = b;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        split_item(it);
        n_items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(OP_DATA, s[i]);
    endtask

    // Random line body ending in a newline, optionally with an '@' in it.
    task automatic send_body(input bit with_at);
        int         n;
        int         at_pos;
        logic [7:0] b;
        n = $urandom_range(0, 12);
        if (with_at && n == 0)
            n = 1;
        at_pos = with_at ? $urandom_range(0, n - 1) : -1;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0)
                b = 8'($urandom_range(255));
            else
                b = 8'($urandom_range(32, 126));
            if (i == at_pos)
                b = CH_AT;
            send_item(OP_DATA, b);
        end
        send_item(OP_DATA, CH_NL);
    endtask

    task automatic send_random_line();
        int r;
        int len;
        r = $urandom_range(99);
        if (r < 25) begin
            send_text("From ");
            send_body($urandom_range(1));
        end else if (r < 38) begin
            send_text(">From ");
            send_body($urandom_range(1));
        end else if (r < 55) begin
            // prefix cut short at every depth of both tags
            if ($urandom_range(1)) begin
                len = $urandom_range(1, 4);
                for (int i = 1; i <= len; i++)
                    send_item(OP_DATA, tag_at(i));
            end else begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                    send_item(OP_DATA, tag_at(i));
            end
            if ($urandom_range(2) == 0)
                send_item(OP_DATA, CH_NL);
            else
                send_item(OP_DATA, 8'($urandom_range(255)));
            if ($urandom_range(1))
                send_body(1'b0);
        end else if (r < 82) begin
            send_body($urandom_range(3) == 0);
        end else if (r < 92) begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                send_item(OP_DATA, 8'($urandom_range(255)));
        end else if (r < 96) begin
            send_item(OP_EOI, 8'($urandom_range(255)));
        end else begin
            // end of input in the middle of a prefix or a separator line
            len = $urandom_range(1, 6);
            for (int i = 1; i < len; i++)
                send_item(OP_DATA, tag_at(i));
            send_item(OP_EOI, 8'h00);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            n_results++;
            if (split_results_q.size() == 0) begin
                report_bad($sformatf("unexpected result kind %0d byte %02h last %0b",
                                     o_result.kind, o_result.out_byte, o_result.last));
            end else begin
                want = split_results_q.pop_front();
                if (o_result.kind !== want.kind)
                    report_bad($sformatf("result %0d kind %0d, want %0d",
                                         n_results, o_result.kind, want.kind));
                if (o_result.out_byte !== want.out_byte)
                    report_bad($sformatf("result %0d byte %02h, want %02h",
                                         n_results, o_result.out_byte, want.out_byte));
                if (o_result.last !== want.last)
                    report_bad($sformatf("result %0d last %0b, want %0b",
                                         n_results, o_result.last, want.last));
            end
        end
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // bytes ahead of any separator, byte extremes, newline back to line start
    task automatic test_plain_bytes();
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, 8'hFF);
        send_item(OP_DATA, CH_NL);
    endtask

    // first separator opens a message; second closes it and warns on no '@'
    task automatic test_separators();
        send_text("From @\n");
        send_text("From \n");
    endtask

    task automatic test_quote();
        send_text(">From ");
        send_item(OP_DATA, CH_NL);
    endtask

    // prefix broken by a newline: the following "F" is plain text
    task automatic test_failed_match();
        send_text("Fr\nF\n");
    endtask

    // held 'F' dropped, open message closed, second end of input is silent
    task automatic test_end_of_input();
        send_item(OP_DATA, CH_F);
        send_item(OP_EOI, 8'hFF);
        send_item(OP_EOI, 8'h00);
    endtask

    task automatic test_random(input int snd_pct, input int rcv_pct, input int n);
        int stop_at;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        stop_at       = n_items + n;
        while (n_items < stop_at)
            send_random_line();
    endtask

    initial begin
        push     <= 1'b0;
        pop      <= 1'b0;
        i_item   <= '0;
        i_rst_n  <= 1'b0;
        pst      = ST_LSTART;
        seen_at  = 1'b0;
        msg_open = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_plain_bytes();
        test_separators();
        test_quote();
        test_failed_match();
        test_end_of_input();
        test_random(36, 45, 170);
        test_random(45, 36, 170);
        test_random(0, 0, 170);
        push <= 1'b0;

        for (int w = 0; w < DRAIN_LIMIT && split_results_q.size() != 0; w++)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (split_results_q.size() != 0)
            report_bad($sformatf("%0d results never arrived", split_results_q.size()));

        $display("Sent %0d items (%0d end-of-input), checked %0d results in %0d cycles.",
                 n_items, n_eoi, n_results, cycle_cnt);
        $display("Separators %0d, missing-at warnings %0d, unquoted lines %0d, mismatches %0d.",
                 n_seps, n_warns, n_quotes, n_bad);
        if (n_bad == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/mss_pkg.sv
sv/mss_front.sv
sv/mss_cmd_fifo.sv
sv/mss_back.sv
sv/mbox_stream_splitter_unit.sv
tb/sv/tb_top.sv
